### hw/rtl/ir_pdft_pkg.sv
// Shared types and constants for the IR pulse-distance frame transmitter.
// No dependencies; imported by the queue, encoder and top-level modules.
`timescale 1ns / 1ps

package ir_pdft_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BYTE_W      = 8;
  localparam int FRAME_W     = 3 * BYTE_W;
  localparam int QCNT_W      = 4;

  // word kinds carried on tuser
  localparam logic MODE_TICK    = 1'b0;
  localparam logic MODE_ENQUEUE = 1'b1;

  typedef logic [FRAME_W-1:0] frame_t;

  typedef struct packed {
    frame_t             head;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   count_nxt;
    logic               empty;
    logic               full;
  } q_status_t;

endpackage

### hw/rtl/ir_pulse_distance_frame_transmitter.sv
// Top level: stream ports, frame queue, pulse-distance encoder and result register.
// Depends on ir_pdft_pkg, ir_pdft_queue and ir_pdft_encoder.
`timescale 1ns / 1ps
//
//  channel | ports     | tdata (low bit up)                        | side bits
//  --------+-----------+-------------------------------------------+---------------------
//  input   | in_t*     | address_byte, command_byte, value_byte    | tuser: mode
//  result  | out_t*    | carrier_on, queue_count, accepted, pad    | tlast: frame_done
//
//  One word in, one word out; a word is accepted every cycle while the result
//  register is empty or being drained. The result register gives each answer in
//  the next cycle. Synchronous active-low reset empties the queue and turns the
//  carrier off. A stalled result blocks input only while out_tready is low.

module ir_pulse_distance_frame_transmitter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address_byte, command_byte, value_byte
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // carrier_on, queue_count[3:0], accepted, 2'b0
  output logic        out_tlast
);
  import ir_pdft_pkg::*;

  logic              in_acc;
  logic              push_req;
  logic              push_ok;
  logic              tick;
  logic              pop;
  logic              carrier;
  logic              carrier_nxt;
  frame_t            push_frame;
  q_status_t         q_st;

  logic              out_valid_r;
  logic              carrier_r;
  logic [QCNT_W-1:0] qcnt_r;
  logic              acc_r;
  logic              done_r;

  assign in_tready  = ~out_valid_r | out_tready;
  assign in_acc     = in_tvalid & in_tready;
  assign push_req   = in_acc & (in_tuser == MODE_ENQUEUE);
  assign tick       = in_acc & (in_tuser == MODE_TICK) & ~q_st.empty;
  assign push_frame = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};

  ir_pdft_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_req   (push_req),
    .push_frame (push_frame),
    .pop        (pop),
    .push_ok    (push_ok),
    .status     (q_st)
  );

  ir_pdft_encoder u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .head        (q_st.head),
    .carrier     (carrier),
    .carrier_nxt (carrier_nxt),
    .done        (pop)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      carrier_r <= carrier_nxt;
      qcnt_r    <= QCNT_W'(q_st.count_nxt);
      acc_r     <= push_ok;
      done_r    <= pop;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, acc_r, qcnt_r, carrier_r};
  assign out_tlast  = done_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_carrier_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_st.empty |-> !carrier)
    else $error("carrier on with empty queue");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> q_st.count == $past(q_st.count) + CNT_W'(1))
    else $error("stored frame not counted");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(acc_r && done_r))
    else $error("store and pop flagged in one word");
`endif

endmodule

### hw/rtl/ir_pdft_queue.sv
// Frame FIFO: register-based store with wrapping read/write pointers and fill count.
// Depends on ir_pdft_pkg.
`timescale 1ns / 1ps

module ir_pdft_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_req,
  input  ir_pdft_pkg::frame_t   push_frame,
  input  logic                  pop,
  output logic                  push_ok,
  output ir_pdft_pkg::q_status_t status
);
  import ir_pdft_pkg::*;

  frame_t             store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push_ok = push_req & ~full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_r);
      cnt_nxt    = cnt_r + CNT_W'(1);
    end else if (pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
      cnt_nxt    = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      store_r[wr_ptr_r] <= push_frame;
    end
  end

  assign status.head      = store_r[rd_ptr_r];
  assign status.count     = cnt_r;
  assign status.count_nxt = cnt_nxt;
  assign status.empty     = (cnt_r == '0);
  assign status.full      = full;

endmodule

### hw/rtl/ir_pdft_encoder.sv
// Pulse-distance sequencer: header, three data bytes, nibble-sum checksum, stop bit.
// Depends on ir_pdft_pkg; advances one step per tick with a frame at the queue head.
`timescale 1ns / 1ps

module ir_pdft_encoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick,
  input  ir_pdft_pkg::frame_t head,
  output logic                carrier,
  output logic                carrier_nxt,
  output logic                done
);
  import ir_pdft_pkg::*;

  localparam logic [4:0] HDR_OFF_TICK = 5'd17;
  localparam logic [4:0] HDR_END_TICK = 5'd25;
  localparam logic [3:0] BYTE_BITS    = 4'd8;
  localparam logic [3:0] CSUM_BITS    = 4'd5;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ADDRESS, PH_COMMAND, PH_VALUE, PH_CHECKSUM
  } phase_t;

  typedef enum logic [2:0] {
    BP_IDLE, BP_ZERO_ON, BP_ONE_ON, BP_SPACE0, BP_SPACE1
  } bit_phase_t;

  phase_t     phase_r, phase_nxt;
  bit_phase_t bp_r, bp_nxt;
  logic [4:0] hdr_r, hdr_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       carrier_r;
  logic       bit_end;
  logic [3:0] pos_inc;
  logic [3:0] csum;
  logic [7:0] cur_byte;
  logic       cur_bit;

  assign csum = head[3:0] + head[7:4] + head[11:8] + head[15:12]
              + head[19:16] + head[23:20];

  always_comb begin
    case (phase_r)
      PH_ADDRESS: cur_byte = head[23:16];
      PH_COMMAND: cur_byte = head[15:8];
      default:    cur_byte = head[7:0];
    endcase
    if (phase_r == PH_CHECKSUM) begin
      cur_bit = pos_r[2] ? 1'b0 : csum[~pos_r[1:0]];
    end else begin
      cur_bit = cur_byte[~pos_r];
    end
  end

  assign pos_inc = {1'b0, pos_r} + 4'd1;

  always_comb begin
    phase_nxt   = phase_r;
    bp_nxt      = bp_r;
    hdr_nxt     = hdr_r;
    pos_nxt     = pos_r;
    carrier_nxt = carrier_r;
    bit_end     = 1'b0;
    done        = 1'b0;
    if (tick) begin
      if (phase_r == PH_HEADER) begin
        if (hdr_r == '0) begin
          carrier_nxt = 1'b1;
        end else if (hdr_r == HDR_OFF_TICK) begin
          carrier_nxt = 1'b0;
        end else if (hdr_r == HDR_END_TICK) begin
          phase_nxt = PH_ADDRESS;
        end
        hdr_nxt = hdr_r + 5'd1;
      end else begin
        case (bp_r)
          BP_ZERO_ON: begin
            carrier_nxt = 1'b0;
            bp_nxt      = BP_IDLE;
            bit_end     = 1'b1;
          end
          BP_ONE_ON: begin
            carrier_nxt = 1'b0;
            bp_nxt      = BP_SPACE0;
          end
          BP_SPACE0: begin
            bp_nxt = BP_SPACE1;
          end
          BP_SPACE1: begin
            bp_nxt  = BP_IDLE;
            bit_end = 1'b1;
          end
          default: begin
            carrier_nxt = 1'b1;
            bp_nxt      = cur_bit ? BP_ONE_ON : BP_ZERO_ON;
          end
        endcase
        if (bit_end) begin
          pos_nxt = pos_inc[2:0];
          if (phase_r == PH_CHECKSUM) begin
            if (pos_inc >= CSUM_BITS) begin
              phase_nxt = PH_HEADER;
              hdr_nxt   = '0;
              bp_nxt    = BP_IDLE;
              pos_nxt   = '0;
              done      = 1'b1;
            end
          end else if (pos_inc >= BYTE_BITS) begin
            pos_nxt = '0;
            case (phase_r)
              PH_ADDRESS: phase_nxt = PH_COMMAND;
              PH_COMMAND: phase_nxt = PH_VALUE;
              default:    phase_nxt = PH_CHECKSUM;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      bp_r      <= BP_IDLE;
      hdr_r     <= '0;
      pos_r     <= '0;
      carrier_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      bp_r      <= bp_nxt;
      hdr_r     <= hdr_nxt;
      pos_r     <= pos_nxt;
      carrier_r <= carrier_nxt;
    end
  end

  assign carrier = carrier_r;

endmodule
